FILE: hdl/nbrtab_pkg.sv
// Shared types, codes and sizes for the neighbour table with hello aging.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package nbrtab_pkg;

    // Table size and the widths that follow from it.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths of the ports.
    localparam int ADDRESS_W     = 32;
    localparam int SEQUENCE_W    = 16;
    localparam int TIME_W        = 16;
    localparam int TIMEOUT_W     = 8;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_INDEX_W = 4;
    localparam int COUNT_W       = 5;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [ADDRESS_W-1:0]     address_t;
    typedef logic [SEQUENCE_W-1:0]    sequence_t;
    typedef logic [TIME_W-1:0]        time_t;
    typedef logic [TIMEOUT_W-1:0]     timeout_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [ENTRY_INDEX_W-1:0] entry_index_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // Operation codes of an input beat.
    localparam logic OP_HELLO = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_OWN_ADDRESS   = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // Result status codes.
    localparam status_t ST_SELF      = 3'd0;
    localparam status_t ST_REFRESHED = 3'd1;
    localparam status_t ST_STALE     = 3'd2;
    localparam status_t ST_INSERTED  = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_TICK      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input beat and start a scan
        logic step;    // advance the scan by one entry
        logic commit;  // move the finished result to the output register
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // the scan finishes in this step
        logic out_free;   // the output register can take a result now
    } dp_status_t;

endpackage

FILE: hdl/nbrtab_ctrl.sv
// Controller state machine for the neighbour table.
// Depends on nbrtab_pkg; drives commands into nbrtab_dp.
module nbrtab_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  nbrtab_pkg::dp_status_t dp_status,
    output nbrtab_pkg::ctl_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (dp_status.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (dp_status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/nbrtab_dp.sv
// Datapath of the neighbour table: entry memory, scan pointers, configuration
// registers and the output register. Depends on nbrtab_pkg; steered by nbrtab_ctrl.
module nbrtab_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nbrtab_pkg::ctl_cmd_t     cmd,
    output nbrtab_pkg::dp_status_t   dp_status,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     operation,
    input  nbrtab_pkg::address_t     sender_address,
    input  nbrtab_pkg::sequence_t    hello_sequence,
    output logic                     result_valid,
    input  logic                     result_stall,
    output nbrtab_pkg::status_t      status,
    output nbrtab_pkg::entry_index_t entry_index,
    output nbrtab_pkg::count_t       neighbour_count,
    output nbrtab_pkg::count_t       removed_count
);

    // Entry memory; read data is registered.
    nbrtab_pkg::address_t  entry_address_reg   [nbrtab_pkg::TABLE_DEPTH];
    nbrtab_pkg::sequence_t entry_sequence_reg  [nbrtab_pkg::TABLE_DEPTH];
    nbrtab_pkg::time_t     entry_last_seen_reg [nbrtab_pkg::TABLE_DEPTH];

    nbrtab_pkg::address_t  rd_address_reg;
    nbrtab_pkg::sequence_t rd_sequence_reg;
    nbrtab_pkg::time_t     rd_last_seen_reg;

    // Configuration and persistent state.
    nbrtab_pkg::address_t own_address_reg;
    nbrtab_pkg::timeout_t timeout_reg;
    nbrtab_pkg::cnt_t     occ_reg, occ_next;
    nbrtab_pkg::time_t    time_reg, time_next;

    // Captured beat and scan state.
    logic                  op_reg, op_next;
    nbrtab_pkg::address_t  addr_reg, addr_next;
    nbrtab_pkg::sequence_t seq_reg, seq_next;
    nbrtab_pkg::cnt_t      rd_ptr_reg, rd_ptr_next;
    nbrtab_pkg::cnt_t      wr_ptr_reg, wr_ptr_next;
    nbrtab_pkg::cnt_t      rem_reg, rem_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    nbrtab_pkg::idx_t      cmp_idx_reg, cmp_idx_next;

    // Pending result, held until the output register is free.
    nbrtab_pkg::status_t   pend_status_reg, pend_status_next;
    nbrtab_pkg::idx_t      pend_idx_reg, pend_idx_next;
    nbrtab_pkg::cnt_t      pend_rem_reg, pend_rem_next;

    // Output register.
    logic                  out_vld_reg, out_vld_next;
    nbrtab_pkg::status_t   res_status_reg;
    nbrtab_pkg::idx_t      res_idx_reg;
    nbrtab_pkg::cnt_t      res_count_reg;
    nbrtab_pkg::cnt_t      res_rem_reg;

    // Memory write port.
    logic                  wr_en;
    nbrtab_pkg::idx_t      wr_idx;
    nbrtab_pkg::address_t  wr_address;
    nbrtab_pkg::sequence_t wr_sequence;
    nbrtab_pkg::time_t     wr_last_seen;

    logic              rd_more;
    logic              rd_fire;
    logic              is_self;
    logic              match;
    logic              scan_done;
    logic              expired;
    nbrtab_pkg::time_t idle;

    assign cfg_ready = 1'b1;

    assign rd_more   = (rd_ptr_reg < occ_reg);
    assign rd_fire   = cmd.step && rd_more;
    assign is_self   = (addr_reg == own_address_reg);
    assign match     = cmp_vld_reg && (rd_address_reg == addr_reg);
    assign idle      = time_reg - rd_last_seen_reg;
    assign expired   = (idle > nbrtab_pkg::time_t'(timeout_reg));

    always_comb
    begin
        if (op_reg == nbrtab_pkg::OP_TICK)
        begin
            scan_done = !cmp_vld_reg && !rd_more;
        end
        else
        begin
            scan_done = is_self || match || (!cmp_vld_reg && !rd_more);
        end
    end

    assign dp_status.scan_done = scan_done;
    assign dp_status.out_free  = !out_vld_reg || !result_stall;

    always_comb
    begin
        occ_next         = occ_reg;
        time_next        = time_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        seq_next         = seq_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        rem_next         = rem_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        pend_status_next = pend_status_reg;
        pend_idx_next    = pend_idx_reg;
        pend_rem_next    = pend_rem_reg;
        wr_en            = 1'b0;
        wr_idx           = wr_ptr_reg[nbrtab_pkg::IDX_W-1:0];
        wr_address       = rd_address_reg;
        wr_sequence      = rd_sequence_reg;
        wr_last_seen     = rd_last_seen_reg;

        if (cmd.load)
        begin
            op_next      = operation;
            addr_next    = sender_address;
            seq_next     = hello_sequence;
            rd_ptr_next  = '0;
            wr_ptr_next  = '0;
            rem_next     = '0;
            cmp_vld_next = 1'b0;
            if (operation == nbrtab_pkg::OP_TICK)
            begin
                time_next = time_reg + 1'b1;
            end
        end

        if (cmd.step)
        begin
            cmp_vld_next = rd_more;
            cmp_idx_next = rd_ptr_reg[nbrtab_pkg::IDX_W-1:0];
            if (rd_more)
            begin
                rd_ptr_next = nbrtab_pkg::cnt_t'(rd_ptr_reg + 1'b1);
            end

            if (op_reg == nbrtab_pkg::OP_TICK)
            begin
                // Compaction: survivors are copied down to the write pointer.
                if (cmp_vld_reg)
                begin
                    if (expired)
                    begin
                        rem_next = nbrtab_pkg::cnt_t'(rem_reg + 1'b1);
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_ptr_next = nbrtab_pkg::cnt_t'(wr_ptr_reg + 1'b1);
                    end
                end
                if (scan_done)
                begin
                    occ_next         = wr_ptr_reg;
                    pend_status_next = nbrtab_pkg::ST_TICK;
                    pend_idx_next    = '0;
                    pend_rem_next    = rem_reg;
                end
            end
            else if (scan_done)
            begin
                pend_rem_next = '0;
                wr_address    = addr_reg;
                wr_sequence   = seq_reg;
                wr_last_seen  = time_reg;
                if (is_self)
                begin
                    pend_status_next = nbrtab_pkg::ST_SELF;
                    pend_idx_next    = '0;
                end
                else if (match)
                begin
                    pend_idx_next = cmp_idx_reg;
                    wr_idx        = cmp_idx_reg;
                    if (seq_reg > rd_sequence_reg)
                    begin
                        wr_en            = 1'b1;
                        pend_status_next = nbrtab_pkg::ST_REFRESHED;
                    end
                    else
                    begin
                        pend_status_next = nbrtab_pkg::ST_STALE;
                    end
                end
                else if (occ_reg < nbrtab_pkg::cnt_t'(nbrtab_pkg::TABLE_DEPTH))
                begin
                    wr_en            = 1'b1;
                    wr_idx           = occ_reg[nbrtab_pkg::IDX_W-1:0];
                    occ_next         = nbrtab_pkg::cnt_t'(occ_reg + 1'b1);
                    pend_status_next = nbrtab_pkg::ST_INSERTED;
                    pend_idx_next    = occ_reg[nbrtab_pkg::IDX_W-1:0];
                end
                else
                begin
                    pend_status_next = nbrtab_pkg::ST_FULL;
                    pend_idx_next    = '0;
                end
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.commit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            timeout_reg     <= nbrtab_pkg::TIMEOUT_RESET;
            occ_reg         <= '0;
            time_reg        <= '0;
            cmp_vld_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            occ_reg     <= occ_next;
            time_reg    <= time_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    nbrtab_pkg::REG_OWN_ADDRESS:   own_address_reg <= cfg_data;
                    nbrtab_pkg::REG_TIMEOUT_TICKS: timeout_reg     <= cfg_data[7:0];
                    default:                       own_address_reg <= own_address_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        seq_reg         <= seq_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        rem_reg         <= rem_next;
        cmp_idx_reg     <= cmp_idx_next;
        pend_status_reg <= pend_status_next;
        pend_idx_reg    <= pend_idx_next;
        pend_rem_reg    <= pend_rem_next;
        if (cmd.commit)
        begin
            res_status_reg <= pend_status_reg;
            res_idx_reg    <= pend_idx_reg;
            res_count_reg  <= occ_reg;
            res_rem_reg    <= pend_rem_reg;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_address_reg[wr_idx]   <= wr_address;
            entry_sequence_reg[wr_idx]  <= wr_sequence;
            entry_last_seen_reg[wr_idx] <= wr_last_seen;
        end
        if (rd_fire)
        begin
            rd_address_reg   <= entry_address_reg[rd_ptr_reg[nbrtab_pkg::IDX_W-1:0]];
            rd_sequence_reg  <= entry_sequence_reg[rd_ptr_reg[nbrtab_pkg::IDX_W-1:0]];
            rd_last_seen_reg <= entry_last_seen_reg[rd_ptr_reg[nbrtab_pkg::IDX_W-1:0]];
        end
    end

    assign result_valid    = out_vld_reg;
    assign status          = res_status_reg;
    assign entry_index     = nbrtab_pkg::entry_index_t'(res_idx_reg);
    assign neighbour_count = nbrtab_pkg::count_t'(res_count_reg);
    assign removed_count   = nbrtab_pkg::count_t'(res_rem_reg);

endmodule

FILE: hdl/neighbour_table_hello_aging.sv
// Flow: each beat is loaded, scanned and committed to the output register; a hello scan ends
// at a self match, at the sender or at the end of the table, a tick scan walks every entry once.
// Throughput: one beat at a time, set by the one-entry-per-cycle scan; the next beat is
// accepted once its result enters the output register, even while that result waits.
// Reset: rst_n clears occupancy, the time counter, the registers (timeout to ten) and all
// valid flags at once; the entry memory is not cleared and needs no clearing pass.
module neighbour_table_hello_aging (
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write channel.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [31:0]              cfg_data,
    // Input channel: one hello or one tick per beat.
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic                     operation,
    input  nbrtab_pkg::address_t     sender_address,
    input  nbrtab_pkg::sequence_t    hello_sequence,
    // Result channel: exactly one result beat per input beat.
    output logic                     result_valid,
    input  logic                     result_stall,
    output nbrtab_pkg::status_t      status,
    output nbrtab_pkg::entry_index_t entry_index,
    output nbrtab_pkg::count_t       neighbour_count,
    output nbrtab_pkg::count_t       removed_count
);

    // The controller sequences each beat through load, a scan of the valid entries, and
    // a commit into the output register. The datapath holds the entry memory, whose
    // valid entries always occupy the lowest slots in insertion order.
    //
    // A hello scans until it finds the sender; it then refreshes that entry when the new
    // sequence is strictly greater, or appends the sender at the end when it is unknown
    // and the table has room. A tick advances the time counter first and then walks the
    // whole table once, copying each surviving entry down to a separate write pointer,
    // so that aged entries drop out and the survivors close up without losing order.
    nbrtab_pkg::ctl_cmd_t   cmd;
    nbrtab_pkg::dp_status_t dp_status;

    nbrtab_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_status  (dp_status),
        .cmd        (cmd)
    );

    nbrtab_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_status       (dp_status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .sender_address  (sender_address),
        .hello_sequence  (hello_sequence),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .status          (status),
        .entry_index     (entry_index),
        .neighbour_count (neighbour_count),
        .removed_count   (removed_count)
    );

endmodule

FILE: hdl/nbrtab_chk.sv
// Port-level checker for the neighbour table, attached to the top level by bind.
// Depends on nbrtab_pkg.
module nbrtab_chk (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_stall,
    input logic                     result_valid,
    input logic                     result_stall,
    input nbrtab_pkg::status_t      status,
    input nbrtab_pkg::entry_index_t entry_index,
    input nbrtab_pkg::count_t       neighbour_count,
    input nbrtab_pkg::count_t       removed_count
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(neighbour_count))
    else $error("stalled result beat changed");

    // Only one beat is in flight: an accepted beat closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("input accepted again before the result was formed");

    // Only ticks remove entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != nbrtab_pkg::ST_TICK) |-> removed_count == '0)
    else $error("hello result reports removed entries");

    // Self, full and tick results carry no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == nbrtab_pkg::ST_SELF || status == nbrtab_pkg::ST_FULL
            || status == nbrtab_pkg::ST_TICK) |-> entry_index == '0)
    else $error("slot reported on a result without one");

    // The count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> neighbour_count <= nbrtab_pkg::count_t'(nbrtab_pkg::TABLE_DEPTH))
    else $error("neighbour count beyond table size");

endmodule

bind neighbour_table_hello_aging nbrtab_chk u_nbrtab_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .status          (status),
    .entry_index     (entry_index),
    .neighbour_count (neighbour_count),
    .removed_count   (removed_count)
);
